// ===== design/sat_pkg.sv =====
// shared types and codes for the sorted array table
`default_nettype none

package sat_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] key;
        logic [INDEX_W-1:0] index;
    } sat_req_t;

    typedef struct packed {
        logic               idle;
        logic               done;
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
    } sat_stat_t;

endpackage

`default_nettype wire

// ===== design/sat_seq.sv =====
// key memory and the sequencer that searches and shifts it one entry at a time
`default_nettype none

module sat_seq #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sat_pkg::sat_req_t req,
    input  logic              rsp_ready,
    output sat_pkg::sat_stat_t stat
);
    import sat_pkg::*;

    localparam int KW    = (KEY_WIDTH < VALUE_W) ? KEY_WIDTH : VALUE_W;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [KW-1:0]     result_reg, result_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic [KW-1:0]     mem [CAPACITY];
    logic [KW-1:0]     rd_data_reg;
    logic [CW-1:0]     rd_ptr;
    logic [AW-1:0]     rd_addr;
    logic              we;
    logic [AW-1:0]     wr_addr;
    logic [KW-1:0]     wr_data;
    logic              not_less;
    logic              idx_ok;

    // single compare unit: stored key against the key being inserted
    assign not_less = (rd_data_reg >= key_reg);
    assign idx_ok   = (CMP_W'(req.index) < CMP_W'(count_reg));

    always_comb
    begin
        unique case (cmd_reg)
            CMD_INSERT: rd_ptr = k_reg - 1'b1;
            CMD_REMOVE: rd_ptr = k_reg + 1'b1;
            default:    rd_ptr = k_reg;
        endcase
    end
    assign rd_addr = rd_ptr[AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        result_next = result_reg;
        status_next = status_reg;
        we          = 1'b0;
        wr_addr     = k_reg[AW-1:0];
        wr_data     = rd_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = req.cmd;
                    key_next    = req.key[KW-1:0];
                    result_next = '0;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    unique case (req.cmd) inside
                        CMD_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                k_next     = count_reg;
                                count_next = count_reg + 1'b1;
                                state_next = S_RD;
                            end
                        end
                        CMD_LOOKUP, CMD_REMOVE:
                        begin
                            if (!idx_ok)
                                status_next = ST_RANGE;
                            else
                            begin
                                k_next     = CW'(req.index);
                                state_next = S_RD;
                                if (req.cmd == CMD_REMOVE)
                                    count_next = count_reg - 1'b1;
                            end
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_EV;
                if (cmd_reg == CMD_INSERT && k_reg == '0)
                begin
                    // reached the bottom: new key is the smallest
                    we         = 1'b1;
                    wr_data    = key_reg;
                    state_next = S_FIN;
                end
                else if (cmd_reg == CMD_REMOVE && k_reg >= count_reg)
                    state_next = S_FIN;
            end
            S_EV:
            begin
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        we = 1'b1;
                        if (not_less)
                        begin
                            k_next     = k_reg - 1'b1;
                            state_next = S_RD;
                        end
                        else
                        begin
                            wr_data    = key_reg;
                            state_next = S_FIN;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        we         = 1'b1;
                        k_next     = k_reg + 1'b1;
                        state_next = S_RD;
                    end
                    default:
                    begin
                        result_next = rd_data_reg;
                        state_next  = S_FIN;
                    end
                endcase
            end
            S_FIN:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        k_reg      <= k_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    // simple dual port key memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign stat.idle   = (state_reg == S_IDLE);
    assign stat.done   = (state_reg == S_FIN);
    assign stat.value  = VALUE_W'(result_reg);
    assign stat.status = status_reg;
    assign stat.count  = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("key count above capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && status_reg == ST_FULL) |-> count_reg == CW'(CAPACITY))
        else $error("full status on a table that is not full");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && req.cmd == CMD_INSERT
            && count_reg != CW'(CAPACITY))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not bump the count");

    a_remove_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV && cmd_reg == CMD_REMOVE) |-> k_reg < count_reg)
        else $error("remove shift ran past the end of the table");

endmodule

`default_nettype wire

// ===== design/sorted_array_table_top.sv =====
// top level of the sorted array table: stream ports, result register, sequencer
// Keeps up to CAPACITY keys in ascending order in a simple dual port memory. One
// command item is taken at a time; s_tready is high only while the sequencer is
// idle. Insert walks down from the top of the table, through each stored key
// that is not less than the new one (read, then compare and move up one slot),
// and writes the new key above the first smaller one or at the bottom. Remove
// moves every key above the index down one slot, each with a read and a write.
// Lookup reads the entry at the index; refused commands and the unused code go
// straight to the result.
// The memory gives one read and one write per cycle, and there is a single key
// comparator. A finished result sits in an output register, so the next
// command can be taken while the previous result still waits on m_tready.
// Keys keep only their low KEY_WIDTH bits; entry_count reports the low 7 bits
// of the count. No clearing pass is needed after reset.
`default_nettype none

module sorted_array_table_top #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command[1:0], value[33:2], index[39:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // result_value[31:0], status[33:32],
                                   // entry_count[40:34], zero fill[47:41]
);
    import sat_pkg::*;

    localparam int OUT_BITS = VALUE_W + STAT_W + COUNT_W;
    localparam int OUT_W    = 48;

    sat_req_t  req;
    sat_stat_t stat;
    logic      start;
    logic      rsp_ready;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // unpack the command item, lowest field first
    assign req.cmd   = s_tdata[CMD_W-1:0];
    assign req.key   = s_tdata[CMD_W +: VALUE_W];
    assign req.index = s_tdata[CMD_W+VALUE_W +: INDEX_W];

    assign s_tready  = stat.idle;
    assign start     = s_tvalid && s_tready;

    // result register is free when empty or being drained this cycle
    assign rsp_ready = !m_tvalid_reg || m_tready;

    sat_seq #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .rsp_ready (rsp_ready),
        .stat      (stat)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        if (stat.done && rsp_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(OUT_W - OUT_BITS){1'b0}}, stat.count, stat.status, stat.value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
